// File: design/teq_pkg.sv
// Shared types, codes and helpers for the timer event queue.
`timescale 1ns / 1ps
package teq_pkg;

  localparam int KindW   = 3;
  localparam int DelayW  = 16;
  localparam int SlotW   = 4;
  localparam int StatusW = 2;
  localparam int EntryW  = 4;
  localparam int TimeW   = 32;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_POLL   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_TICK   = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_NOT_DUE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RD_ZERO      = 3'd0,
    RD_SCAN_NEXT = 3'd1,
    RD_HEAD      = 3'd2,
    RD_LINK      = 3'd3,
    RD_SLOT      = 3'd4
  } rd_sel_e;

  typedef enum logic [1:0] {
    ENT_ZERO = 2'd0,
    ENT_NEW  = 2'd1,
    ENT_HEAD = 2'd2
  } ent_e;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    scan_start;
    logic    scan_next;
    logic    walk_init;
    logic    walk_step;
    logic    ins_a;
    logic    ins_b;
    logic    rem_link;
    logic    unlink_head;
    logic    drop;
    logic    drop_slot;
    logic    sweep_init;
    logic    sweep_step;
    logic    clear_state;
    logic    tick;
    logic    res_set;
    status_e res_status;
    ent_e    res_entry;
    logic    res_fired;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             count_zero;
    logic             count_full;
    logic             slot_ok;
    logic             pend_bit;
    logic             head_is_slot;
    logic             i_lt_count;
    logic             walk_go;
    logic             link_is_slot;
    logic             due;
    logic             sweep_last;
    logic             out_free;
  } stat_t;

  // a lies strictly after b on the wrapping clock
  function automatic logic is_later(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    logic [TimeW-1:0] diff;
    diff = a - b;
    return (diff != '0) && !diff[TimeW-1];
  endfunction

endpackage

// File: design/timer_event_queue.sv
// Timer event queue: sorted list of pending deadlines in fixed slots.
//
// Input channel (in_valid_i / in_stall_o) carries one command beat: kind_i
// selects add, remove, poll, clear or tick; delay_ms_i and slot_i are its
// operands. Output channel (out_valid_o / out_stall_i) returns exactly one
// result beat per command: status, entry slot, fired flag, queue_empty.
// One command is worked on at a time; in_stall_o is low only when idle, so
// a new command beat is taken only after the last one has loaded its result.
// Work from command beat to result beat:
//   tick, unused kinds, full add, slot beyond CAPACITY, empty poll: no read
//   poll, remove of the head, remove of a slot not pending: a single read
//   other remove: walk of the list from the head to the predecessor
//   add: scan for the lowest free slot, then a walk to the insertion point
//   clear: one pending bit is cleared per cycle, over all CAPACITY slots
// The add walk and the free-slot scan each visit one slot per cycle through
// the registered read port of the slot memories; that sets the add time.
// After reset the block sweeps every slot of the pending memory with
// in_stall_o high, then accepts commands. A result beat is held in the
// output register while out_stall_i is high; the next command may already
// be accepted, and its result waits until the register frees.
`timescale 1ns / 1ps
module timer_event_queue import teq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [DelayW-1:0]  delay_ms_i,
  input  logic [SlotW-1:0]   slot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [EntryW-1:0]  entry_o,
  output logic               fired_o,
  output logic               queue_empty_o
);

  cmd_t  cmd;
  stat_t stat;

  teq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  teq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .delay_ms_i    (delay_ms_i),
    .slot_i        (slot_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .entry_o       (entry_o),
    .fired_o       (fired_o),
    .queue_empty_o (queue_empty_o)
  );

endmodule

// File: design/teq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/teq_ctrl.sv
// Controller state machine sequencing add, remove, poll, clear and tick.
`timescale 1ns / 1ps
module teq_ctrl import teq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_SWEEP    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_FREE     = 4'd3;
  localparam logic [3:0] S_WALK     = 4'd4;
  localparam logic [3:0] S_INS_A    = 4'd5;
  localparam logic [3:0] S_INS_B    = 4'd6;
  localparam logic [3:0] S_REM_CHK  = 4'd7;
  localparam logic [3:0] S_REM_WALK = 4'd8;
  localparam logic [3:0] S_POLL_CHK = 4'd9;
  localparam logic [3:0] S_CLEAR    = 4'd10;
  localparam logic [3:0] S_RESP     = 4'd11;

  logic [3:0] state_q, state_d;
  cmd_t       cmd;
  logic       in_stall;

  always_comb begin
    cmd      = '0;
    state_d  = state_q;
    in_stall = 1'b1;
    case (state_q)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.kind)
          KIND_ADD: begin
            if (stat_i.count_full) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_FULL;
              cmd.res_entry  = ENT_ZERO;
              state_d        = S_RESP;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.rd_en      = 1'b1;
              cmd.rd_sel     = RD_ZERO;
              state_d        = S_FREE;
            end
          end
          KIND_REMOVE: begin
            if (!stat_i.slot_ok) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_BAD_SLOT;
              cmd.res_entry  = ENT_ZERO;
              state_d        = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_SLOT;
              state_d    = S_REM_CHK;
            end
          end
          KIND_POLL: begin
            if (stat_i.count_zero) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOT_DUE;
              cmd.res_entry  = ENT_ZERO;
              state_d        = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_d    = S_POLL_CHK;
            end
          end
          KIND_CLEAR: begin
            cmd.sweep_init = 1'b1;
            state_d        = S_CLEAR;
          end
          KIND_TICK: begin
            cmd.tick = 1'b1;
            state_d  = S_RESP;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_FREE: begin
        cmd.rd_en = 1'b1;
        if (stat_i.pend_bit) begin
          cmd.scan_next = 1'b1;
          cmd.rd_sel    = RD_SCAN_NEXT;
        end else begin
          cmd.walk_init = 1'b1;
          cmd.rd_sel    = RD_HEAD;
          state_d       = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.walk_go) begin
          cmd.walk_step = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_LINK;
        end else begin
          state_d = S_INS_A;
        end
      end
      S_INS_A: begin
        cmd.ins_a = 1'b1;
        state_d   = S_INS_B;
      end
      S_INS_B: begin
        cmd.ins_b      = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_entry  = ENT_NEW;
        state_d        = S_RESP;
      end
      S_REM_CHK: begin
        if (!stat_i.pend_bit) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_BAD_SLOT;
          cmd.res_entry  = ENT_ZERO;
          state_d        = S_RESP;
        end else if (stat_i.head_is_slot) begin
          cmd.unlink_head = 1'b1;
          cmd.drop        = 1'b1;
          cmd.drop_slot   = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd.walk_init = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_HEAD;
          state_d       = S_REM_WALK;
        end
      end
      S_REM_WALK: begin
        if (!stat_i.i_lt_count) begin
          cmd.drop      = 1'b1;
          cmd.drop_slot = 1'b1;
          state_d       = S_RESP;
        end else if (stat_i.link_is_slot) begin
          cmd.rem_link  = 1'b1;
          cmd.drop      = 1'b1;
          cmd.drop_slot = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_LINK;
        end
      end
      S_POLL_CHK: begin
        cmd.res_set = 1'b1;
        if (stat_i.due) begin
          cmd.unlink_head = 1'b1;
          cmd.drop        = 1'b1;
          cmd.res_status  = ST_OK;
          cmd.res_entry   = ENT_HEAD;
          cmd.res_fired   = 1'b1;
        end else begin
          cmd.res_status = ST_NOT_DUE;
          cmd.res_entry  = ENT_ZERO;
        end
        state_d = S_RESP;
      end
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          cmd.clear_state = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = in_stall;

endmodule

// File: design/teq_dp.sv
// Datapath: slot memories, list head, count, clock and result register.
`timescale 1ns / 1ps
module teq_dp import teq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [KindW-1:0]  kind_i,
  input  logic [DelayW-1:0] delay_ms_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [EntryW-1:0] entry_o,
  output logic              fired_o,
  output logic              queue_empty_o
);

  localparam int LW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KindW-1:0]   kind_q;
  logic [DelayW-1:0]  delay_q;
  logic [SlotW-1:0]   slot_q;
  logic [TimeW-1:0]   now_q;
  logic [TimeW-1:0]   d_q;
  logic [LW-1:0]      earliest_q;
  logic [CW-1:0]      count_q;
  logic [LW-1:0]      scan_q;
  logic [LW-1:0]      cur_q;
  logic [LW-1:0]      prev_q;
  logic [LW-1:0]      s_q;
  logic [LW-1:0]      ls_q;
  logic               has_prev_q;
  logic [CW-1:0]      i_q;
  logic [LW-1:0]      sw_q;
  status_e            res_status_q;
  logic [EntryW-1:0]  res_entry_q;
  logic               res_fired_q;
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [EntryW-1:0]  out_entry_q;
  logic               out_fired_q;
  logic               out_empty_q;

  logic [LW-1:0]      slot_idx;
  logic [LW-1:0]      rd_addr;
  logic               i_lt_count;
  logic               out_free;

  logic               pend_we;
  logic [LW-1:0]      pend_waddr;
  logic [0:0]         pend_wdata;
  logic [0:0]         pend_rdata;
  logic               dl_we;
  logic [TimeW-1:0]   dl_rdata;
  logic               link_we;
  logic [LW-1:0]      link_waddr;
  logic [LW-1:0]      link_wdata;
  logic [LW-1:0]      link_rdata;
  logic [EntryW-1:0]  res_entry;

  assign slot_idx   = LW'(slot_q);
  assign i_lt_count = i_q < count_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO:      rd_addr = '0;
      RD_SCAN_NEXT: rd_addr = scan_q + LW'(1);
      RD_HEAD:      rd_addr = earliest_q;
      RD_LINK:      rd_addr = link_rdata;
      RD_SLOT:      rd_addr = slot_idx;
      default:      rd_addr = '0;
    endcase
  end

  assign pend_we    = cmd_i.sweep_step || cmd_i.ins_a || cmd_i.drop;
  assign pend_waddr = cmd_i.sweep_step ? sw_q :
                      cmd_i.ins_a      ? s_q  :
                      cmd_i.drop_slot  ? slot_idx : earliest_q;
  assign pend_wdata = cmd_i.ins_a;

  assign dl_we = cmd_i.ins_a;

  assign link_we    = cmd_i.ins_a || (cmd_i.ins_b && has_prev_q) || cmd_i.rem_link;
  assign link_waddr = cmd_i.ins_a ? s_q : cmd_i.ins_b ? prev_q : cur_q;
  assign link_wdata = cmd_i.ins_a ? (i_lt_count ? cur_q : '0) :
                      cmd_i.ins_b ? s_q : ls_q;

  teq_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (pend_rdata)
  );

  teq_ram #(.WIDTH(TimeW), .DEPTH(CAPACITY)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (s_q),
    .wdata_i (d_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (dl_rdata)
  );

  teq_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  always_comb begin
    case (cmd_i.res_entry)
      ENT_NEW:  res_entry = EntryW'(s_q);
      ENT_HEAD: res_entry = EntryW'(earliest_q);
      default:  res_entry = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      earliest_q  <= '0;
      count_q     <= '0;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        now_q <= now_q + TimeW'(1);
      end
      if (cmd_i.clear_state) begin
        earliest_q <= '0;
      end else if (cmd_i.unlink_head) begin
        earliest_q <= (count_q > CW'(1)) ? link_rdata : '0;
      end else if (cmd_i.ins_b && !has_prev_q) begin
        earliest_q <= s_q;
      end
      if (cmd_i.clear_state) begin
        count_q <= '0;
      end else if (cmd_i.ins_b) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.drop) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.sweep_init) begin
        sw_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sw_q <= sw_q + LW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q       <= kind_i;
      delay_q      <= delay_ms_i;
      slot_q       <= slot_i;
      res_status_q <= ST_OK;
      res_entry_q  <= '0;
      res_fired_q  <= 1'b0;
    end else if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_entry_q  <= res_entry;
      res_fired_q  <= cmd_i.res_fired;
    end
    if (cmd_i.scan_start) begin
      scan_q <= '0;
    end else if (cmd_i.scan_next) begin
      scan_q <= scan_q + LW'(1);
    end
    if (cmd_i.walk_init) begin
      d_q        <= now_q + TimeW'(delay_q);
      s_q        <= scan_q;
      cur_q      <= earliest_q;
      i_q        <= '0;
      has_prev_q <= 1'b0;
      ls_q       <= link_rdata;
    end else if (cmd_i.walk_step) begin
      prev_q     <= cur_q;
      has_prev_q <= 1'b1;
      cur_q      <= link_rdata;
      i_q        <= i_q + CW'(1);
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_entry_q  <= res_entry_q;
      out_fired_q  <= res_fired_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  always_comb begin
    stat_o.kind         = kind_q;
    stat_o.count_zero   = (count_q == '0);
    stat_o.count_full   = (count_q == CW'(CAPACITY));
    stat_o.slot_ok      = (32'(slot_q) < 32'(CAPACITY));
    stat_o.pend_bit     = pend_rdata[0];
    stat_o.head_is_slot = (earliest_q == slot_idx);
    stat_o.i_lt_count   = i_lt_count;
    stat_o.walk_go      = i_lt_count && is_later(d_q, dl_rdata);
    stat_o.link_is_slot = (link_rdata == slot_idx);
    stat_o.due          = !is_later(dl_rdata, now_q);
    stat_o.sweep_last   = (sw_q == LW'(CAPACITY - 1));
    stat_o.out_free     = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_o       = out_entry_q;
  assign fired_o       = out_fired_q;
  assign queue_empty_o = out_empty_q;

endmodule

// File: design/teq_checker.sv
// Port-level checks for the timer event queue, bound to the top level.
`timescale 1ns / 1ps
module teq_checker import teq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [StatusW-1:0] status_o,
  input logic [EntryW-1:0]  entry_o,
  input logic               fired_o,
  input logic               queue_empty_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(entry_o)
      && $stable(fired_o) && $stable(queue_empty_o))
    else $error("stalled result beat changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken while another is in work");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> status_o == ST_OK)
    else $error("fired with error status");

  a_full_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_o == '0 && !queue_empty_o)
    else $error("full result with slot or empty queue");

endmodule

bind timer_event_queue teq_checker u_teq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .entry_o       (entry_o),
  .fired_o       (fired_o),
  .queue_empty_o (queue_empty_o)
);

// File: test/tb.sv
// Self-checking testbench for the timer event queue: directed and random commands.
`timescale 1ns / 1ps
module tb;
  import teq_pkg::*;

  localparam int SLOTS      = 16;
  localparam int RandItems  = 1950;
  localparam int IdlePct    = 38;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 4000;
  localparam int DrainWait  = 60;
  localparam int PrintMax   = 30;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [DelayW-1:0] delay;
    logic [SlotW-1:0]  slot;
  } timer_cmd_t;

  typedef struct packed {
    status_e           status;
    logic [EntryW-1:0] entry;
    logic              fired;
    logic              empty;
  } timer_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [KindW-1:0]   kind = '0;
  logic [DelayW-1:0]  delay_ms = '0;
  logic [SlotW-1:0]   slot = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [EntryW-1:0]  entry;
  logic               fired;
  logic               queue_empty;

  timer_cmd_t   cmd_backlog[$];
  timer_reply_t timer_replies[$];

  logic [TimeW-1:0]  due_time [SLOTS] = '{default: '0};
  logic [SlotW-1:0]  link_of  [SLOTS] = '{default: '0};
  logic              slot_busy[SLOTS] = '{default: 1'b0};
  logic [SlotW-1:0]  head_slot = '0;
  int                live_count = 0;
  logic [TimeW-1:0]  clock_ms = '0;

  int  n_sent = 0;
  int  total_cmds = 0;
  int  errors = 0;
  int  n_checked = 0;
  int  n_fired = 0;
  int  n_full = 0;
  int  n_bad = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;
  logic calm;

  assign calm = (n_sent >= 900) && (n_sent < 1250);

  timer_event_queue #(
    .CAPACITY(SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .delay_ms_i   (delay_ms),
    .slot_i       (slot),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .entry_o      (entry),
    .fired_o      (fired),
    .queue_empty_o(queue_empty)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit later_than(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    logic [TimeW-1:0] gap;
    gap = a - b;
    return (gap != '0) && !gap[TimeW-1];
  endfunction

  function automatic void apply_timer_cmd(input timer_cmd_t c);
    timer_reply_t     r;
    logic [TimeW-1:0] due_at;
    int               free;
    int               cur;
    int               prev;
    int               steps;
    bit               has_prev;
    bit               found;
    r.status = ST_OK;
    r.entry  = '0;
    r.fired  = 1'b0;
    case (c.kind)
      KIND_ADD: begin
        free = 0;
        while (free < SLOTS && slot_busy[free]) free++;
        if (live_count >= SLOTS || free >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          due_at   = clock_ms + 32'(c.delay);
          cur      = head_slot;
          prev     = 0;
          has_prev = 1'b0;
          steps    = 0;
          while (steps < live_count && later_than(due_at, due_time[cur])) begin
            prev     = cur;
            has_prev = 1'b1;
            cur      = link_of[cur];
            steps++;
          end
          due_time[free] = due_at;
          link_of[free]  = (steps < live_count) ? SlotW'(cur) : '0;
          if (has_prev) link_of[prev] = SlotW'(free);
          else head_slot = SlotW'(free);
          slot_busy[free] = 1'b1;
          live_count++;
          r.entry = EntryW'(free);
        end
      end
      KIND_REMOVE: begin
        if (!slot_busy[c.slot]) begin
          r.status = ST_BAD_SLOT;
        end else begin
          if (head_slot == c.slot) begin
            head_slot = (live_count > 1) ? link_of[c.slot] : '0;
          end else begin
            cur   = head_slot;
            steps = 0;
            found = 1'b0;
            while (!found && steps < live_count) begin
              if (link_of[cur] == c.slot) begin
                link_of[cur] = link_of[c.slot];
                found = 1'b1;
              end else begin
                cur = link_of[cur];
                steps++;
              end
            end
          end
          slot_busy[c.slot] = 1'b0;
          live_count--;
        end
      end
      KIND_POLL: begin
        if (live_count == 0 || later_than(due_time[head_slot], clock_ms)) begin
          r.status = ST_NOT_DUE;
        end else begin
          r.entry = head_slot;
          r.fired = 1'b1;
          slot_busy[head_slot] = 1'b0;
          head_slot = (live_count > 1) ? link_of[head_slot] : '0;
          live_count--;
        end
      end
      KIND_CLEAR: begin
        slot_busy  = '{default: 1'b0};
        live_count = 0;
        head_slot  = '0;
      end
      KIND_TICK: begin
        clock_ms = clock_ms + 1;
      end
      default: begin
      end
    endcase
    r.empty = (live_count == 0);
    timer_replies.push_back(r);
  endfunction

  function automatic void queue_cmd(input logic [KindW-1:0] k, input int d, input int s);
    cmd_backlog.push_back('{k, DelayW'(d), SlotW'(s)});
  endfunction

  function automatic int pick_delay();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return $urandom_range(0, 3);
    if (p < 85) return $urandom_range(0, 255);
    return $urandom_range(0, 65535);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < PrintMax) begin
      $display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    end
    errors++;
  endtask

  // driver: hold a stalled beat, otherwise offer the next command or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      kind     <= '0;
      delay_ms <= '0;
      slot     <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_timer_cmd('{kind, delay_ms, slot});
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid <= 1'b1;
          kind     <= cmd_backlog[0].kind;
          delay_ms <= cmd_backlog[0].delay;
          slot     <= cmd_backlog[0].slot;
          void'(cmd_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_sent >= 400) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left > 0) || (!calm && $urandom_range(0, 99) < IdlePct);
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (timer_replies.size() == 0) begin
        report_mismatch("unexpected result entry", entry, 0);
      end else begin
        if (status != timer_replies[0].status)
          report_mismatch("status", status, timer_replies[0].status);
        if (entry != timer_replies[0].entry)
          report_mismatch("entry", entry, timer_replies[0].entry);
        if (fired != timer_replies[0].fired)
          report_mismatch("fired", fired, timer_replies[0].fired);
        if (queue_empty != timer_replies[0].empty)
          report_mismatch("queue_empty", queue_empty, timer_replies[0].empty);
        if (timer_replies[0].fired) n_fired++;
        if (timer_replies[0].status == ST_FULL) n_full++;
        if (timer_replies[0].status == ST_BAD_SLOT) n_bad++;
        void'(timer_replies.pop_front());
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb: no progress for %0d cycles", quiet_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    int pick;
    int bias;
    int add_pct;
    logic [KindW-1:0] k;

    queue_cmd(KIND_POLL, 0, 0);
    queue_cmd(KIND_REMOVE, 0, 0);
    queue_cmd(KIND_ADD, 0, 15);
    queue_cmd(KIND_ADD, 65535, 0);
    queue_cmd(KIND_ADD, 0, 7);
    queue_cmd(KIND_ADD, 5, 0);
    queue_cmd(KIND_POLL, 0, 0);
    queue_cmd(KIND_POLL, 0, 0);
    queue_cmd(KIND_POLL, 0, 0);
    for (n = 0; n < 5; n++) queue_cmd(KIND_TICK, 0, 0);
    queue_cmd(KIND_POLL, 65535, 15);
    queue_cmd(KIND_REMOVE, 0, 1);
    queue_cmd(KIND_REMOVE, 0, 15);
    queue_cmd(KIND_ADD, 3, 0);
    queue_cmd(KIND_ADD, 7, 0);
    queue_cmd(KIND_ADD, 3, 0);
    queue_cmd(KIND_REMOVE, 0, 0);
    queue_cmd(3'd5, 65535, 15);
    queue_cmd(3'd6, 0, 0);
    queue_cmd(3'd7, 21845, 10);
    queue_cmd(KIND_CLEAR, 0, 0);
    queue_cmd(KIND_POLL, 0, 0);

    bias = 0;
    for (n = 0; n < RandItems; n++) begin
      if (n % 200 == 0) bias = $urandom_range(0, 2);
      add_pct = (bias == 0) ? 55 : (bias == 1) ? 35 : 20;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) k = KIND_ADD;
      else if (pick < add_pct + 14) k = KIND_REMOVE;
      else if (pick < 98) k = pick[0] ? KIND_POLL : KIND_TICK;
      else if (pick == 98) k = KIND_CLEAR;
      else k = 3'($urandom_range(5, 7));
      queue_cmd(k, pick_delay(),
                ($urandom_range(0, 99) < 75) ? $urandom_range(0, 7) : $urandom_range(0, 15));
    end
    total_cmds = cmd_backlog.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent < total_cmds || timer_replies.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("tb: %0d commands sent, %0d results checked, %0d mismatches",
             n_sent, n_checked, errors);
    $display("tb: %0d timers fired, %0d adds to a full queue, %0d removes of idle slots",
             n_fired, n_full, n_bad);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
